// File: src/rc4_stream_cipher_assert.svh
// assertion macros for the rc4 stream cipher
`ifndef RC4_STREAM_CIPHER_ASSERT_SVH
`define RC4_STREAM_CIPHER_ASSERT_SVH

// same-cycle implication, sampled on clk, off during reset
`define RC4_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define RC4_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: src/rc4_pkg.sv
// shared types and constants for the rc4 stream cipher
`default_nettype none

package rc4_pkg;

	localparam int REG_IDX_W = 2;

	localparam logic [REG_IDX_W-1:0] REG_KEY_LO  = 2'd0;
	localparam logic [REG_IDX_W-1:0] REG_KEY_HI  = 2'd1;
	localparam logic [REG_IDX_W-1:0] REG_KEY_LEN = 2'd2;

	localparam int REG_DATA_W = 64;
	localparam int KEY_LEN_W  = 5;
	localparam logic [KEY_LEN_W-1:0] KEY_LEN_RESET = 5'd16;

	localparam logic CMD_DATA  = 1'b0;
	localparam logic CMD_REKEY = 1'b1;

	typedef struct packed {
		logic       cmd;
		logic [7:0] data;
		logic       last;
	} rc4_item_t;

	typedef struct packed {
		logic [7:0] data;
		logic       rekey_done;
		logic       not_keyed;
		logic       last;
	} rc4_res_t;

	typedef struct packed {
		logic clr;
		logic adv;
	} rc4_kctl_t;

endpackage

`default_nettype wire

// File: src/rc4_keys.sv
// key register file with cyclic key byte pointer
`default_nettype none

module rc4_keys #(
	parameter int MAX_KEY_BYTES = 16
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 wr_en,
	input  wire logic [rc4_pkg::REG_IDX_W-1:0]        wr_index,
	input  wire logic [rc4_pkg::REG_DATA_W-1:0]       wr_data,
	input  wire rc4_pkg::rc4_kctl_t                   kctl,
	output      logic [7:0]                           key_byte
);
	import rc4_pkg::*;

	localparam int KIDX_W = (MAX_KEY_BYTES > 1) ? $clog2(MAX_KEY_BYTES) : 1;

	logic [7:0]           key_q [MAX_KEY_BYTES];
	logic [KEY_LEN_W-1:0] len_q;
	logic [KEY_LEN_W-1:0] len_m1;
	logic [KIDX_W-1:0]    kptr_q;

	always_comb begin
		if (len_q == '0) begin
			len_m1 = '0;
		end else if (len_q > KEY_LEN_W'(MAX_KEY_BYTES)) begin
			len_m1 = KEY_LEN_W'(MAX_KEY_BYTES - 1);
		end else begin
			len_m1 = len_q - 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int b = 0; b < MAX_KEY_BYTES; b++) begin
				key_q[b] <= '0;
			end
			len_q <= KEY_LEN_RESET;
		end else if (wr_en) begin
			for (int b = 0; b < MAX_KEY_BYTES; b++) begin
				if (wr_index == ((b < 8) ? REG_KEY_LO : REG_KEY_HI)) begin
					key_q[b] <= wr_data[(b % 8) * 8 +: 8];
				end
			end
			if (wr_index == REG_KEY_LEN) begin
				len_q <= wr_data[KEY_LEN_W-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kptr_q <= '0;
		end else if (kctl.clr) begin
			kptr_q <= '0;
		end else if (kctl.adv) begin
			if (kptr_q == len_m1[KIDX_W-1:0]) begin
				kptr_q <= '0;
			end else begin
				kptr_q <= kptr_q + 1'b1;
			end
		end
	end

	assign key_byte = key_q[kptr_q];

endmodule

`default_nettype wire

// File: src/rc4_core.sv
// permutation memory and sequencer for key schedule and keystream steps
`default_nettype none

module rc4_core (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output      logic                in_ready,
	input  wire rc4_pkg::rc4_item_t  in_item,
	output      logic                res_valid,
	input  wire logic                res_ready,
	output      rc4_pkg::rc4_res_t   res,
	output      rc4_pkg::rc4_kctl_t  kctl,
	input  wire logic [7:0]          key_byte
);
	import rc4_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE,
		S_FILL,
		S_KA,
		S_KB,
		S_KC,
		S_KD,
		S_DA,
		S_DB,
		S_DC,
		S_RESP
	} state_t;

	state_t    state_q;
	logic [7:0] n_q;
	logic [7:0] i_q;
	logic [7:0] j_q;
	logic [7:0] a_q;
	logic [7:0] b_q;
	logic [7:0] t_q;
	logic       keyed_q;
	rc4_item_t  item_q;
	rc4_res_t   res_q;

	logic [7:0] mem [256];
	logic [7:0] rdata_q;
	logic       mem_we;
	logic [7:0] mem_waddr;
	logic [7:0] mem_wdata;
	logic [7:0] mem_raddr;
	logic [7:0] j_sched;
	logic [7:0] ks;

	assign j_sched = j_q + rdata_q + key_byte;

	// swapped entries win over the stale read
	always_comb begin
		if (t_q == j_q) begin
			ks = a_q;
		end else if (t_q == i_q) begin
			ks = b_q;
		end else begin
			ks = rdata_q;
		end
	end

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = n_q;
		mem_wdata = n_q;
		mem_raddr = n_q;
		kctl      = '0;
		unique case (state_q)
			S_IDLE: begin
				mem_raddr = i_q + 8'd1;
			end
			S_FILL: begin
				mem_we   = 1'b1;
				kctl.clr = 1'b1;
			end
			S_KA: begin
				mem_raddr = n_q;
			end
			S_KB: begin
				mem_raddr = j_sched;
			end
			S_KC: begin
				mem_we    = 1'b1;
				mem_waddr = n_q;
				mem_wdata = rdata_q;
			end
			S_KD: begin
				mem_we    = 1'b1;
				mem_waddr = j_q;
				mem_wdata = a_q;
				kctl.adv  = 1'b1;
			end
			S_DA: begin
				mem_raddr = j_q + rdata_q;
			end
			S_DB: begin
				mem_we    = 1'b1;
				mem_waddr = i_q;
				mem_wdata = rdata_q;
				mem_raddr = a_q + rdata_q;
			end
			S_DC: begin
				mem_we    = 1'b1;
				mem_waddr = j_q;
				mem_wdata = a_q;
			end
			S_RESP: begin
				mem_raddr = n_q;
			end
			default: begin
				mem_raddr = n_q;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		rdata_q <= mem[mem_raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			n_q     <= '0;
			i_q     <= '0;
			j_q     <= '0;
			a_q     <= '0;
			b_q     <= '0;
			t_q     <= '0;
			keyed_q <= 1'b0;
			item_q  <= '0;
			res_q   <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						item_q <= in_item;
						if (in_item.cmd == CMD_REKEY) begin
							n_q     <= '0;
							state_q <= S_FILL;
						end else if (!keyed_q) begin
							res_q   <= '{data: in_item.data, rekey_done: 1'b0,
								not_keyed: 1'b1, last: in_item.last};
							state_q <= S_RESP;
						end else begin
							i_q     <= i_q + 8'd1;
							state_q <= S_DA;
						end
					end
				end
				S_FILL: begin
					n_q <= n_q + 8'd1;
					if (n_q == 8'hFF) begin
						j_q     <= '0;
						state_q <= S_KA;
					end
				end
				S_KA: begin
					state_q <= S_KB;
				end
				S_KB: begin
					a_q     <= rdata_q;
					j_q     <= j_sched;
					state_q <= S_KC;
				end
				S_KC: begin
					state_q <= S_KD;
				end
				S_KD: begin
					n_q <= n_q + 8'd1;
					if (n_q == 8'hFF) begin
						i_q     <= '0;
						j_q     <= '0;
						keyed_q <= 1'b1;
						res_q   <= '{data: 8'h00, rekey_done: 1'b1,
							not_keyed: 1'b0, last: item_q.last};
						state_q <= S_RESP;
					end else begin
						state_q <= S_KA;
					end
				end
				S_DA: begin
					a_q     <= rdata_q;
					j_q     <= j_q + rdata_q;
					state_q <= S_DB;
				end
				S_DB: begin
					b_q     <= rdata_q;
					t_q     <= a_q + rdata_q;
					state_q <= S_DC;
				end
				S_DC: begin
					res_q   <= '{data: item_q.data ^ ks, rekey_done: 1'b0,
						not_keyed: 1'b0, last: item_q.last};
					state_q <= S_RESP;
				end
				S_RESP: begin
					if (res_ready) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign in_ready  = (state_q == S_IDLE);
	assign res_valid = (state_q == S_RESP);
	assign res       = res_q;

endmodule

`default_nettype wire

// File: src/rc4_stream_cipher.sv
// rc4 stream cipher top level with output register
//
// input beats: tuser selects data (0) or rekey (1), tdata is the byte, tlast is
// copied to the result. every beat yields exactly one output beat.
// keys are written on the wr_* port (index 0 key bytes 0-7, 1 key bytes 8-15,
// 2 key length) while the block is idle, a rule for the user that the block does not enforce.
// keyed data beat: after the accept in S_IDLE the core steps through S_DA, S_DB and
// S_DC to S_RESP, the read, swap and keystream read of the 256x8 permutation
// memory (one read and one write port); the next beat is taken back in S_IDLE.
// data before any rekey: passes through with tuser[1] set.
// rekey beat: identity fill of all 256 entries, then S_KA to S_KD for each entry of
// the key schedule; result has zero data and tuser[0] set.
// reset clears the indices, the keyed flag and the key registers (length 16);
// the permutation holds nothing until the first rekey.
// a stalled receiver holds the result in the output register; one more beat
// can be accepted and processed, then the block waits for m_axis_tready.
`default_nettype none

module rc4_stream_cipher #(
	parameter int MAX_KEY_BYTES = 16
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            s_axis_tvalid,
	output      logic                            s_axis_tready,
	input  wire logic [7:0]                      s_axis_tdata,  // data_in
	input  wire logic                            s_axis_tuser,  // command
	input  wire logic                            s_axis_tlast,
	output      logic                            m_axis_tvalid,
	input  wire logic                            m_axis_tready,
	output      logic [7:0]                      m_axis_tdata,  // data_out
	output      logic [1:0]                      m_axis_tuser,  // not_keyed, rekey_done
	output      logic                            m_axis_tlast,
	input  wire logic                            wr_en,
	input  wire logic [rc4_pkg::REG_IDX_W-1:0]   wr_index,
	input  wire logic [rc4_pkg::REG_DATA_W-1:0]  wr_data
);
	import rc4_pkg::*;

	rc4_item_t  in_item;
	rc4_res_t   res;
	rc4_res_t   out_q;
	rc4_kctl_t  kctl;
	logic       res_valid;
	logic       res_ready;
	logic       out_valid_q;
	logic [7:0] key_byte;

	assign in_item = '{cmd: s_axis_tuser, data: s_axis_tdata, last: s_axis_tlast};

	rc4_keys #(
		.MAX_KEY_BYTES(MAX_KEY_BYTES)
	) u_keys (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data),
		.kctl     (kctl),
		.key_byte (key_byte)
	);

	rc4_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_item   (in_item),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res),
		.kctl      (kctl),
		.key_byte  (key_byte)
	);

	assign res_ready = !out_valid_q || m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			out_q       <= '0;
		end else if (res_valid && res_ready) begin
			out_valid_q <= 1'b1;
			out_q       <= res;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_q.data;
	assign m_axis_tuser  = {out_q.not_keyed, out_q.rekey_done};
	assign m_axis_tlast  = out_q.last;

`include "rc4_stream_cipher_assert.svh"

	`RC4_ASSERT_SAME(a_rekey_zero, m_axis_tvalid && m_axis_tuser[0], m_axis_tdata == 8'h00 && !m_axis_tuser[1], "rekey beat with data or not keyed flag")
	`RC4_ASSERT_NEXT(a_one_item, s_axis_tvalid && s_axis_tready, !s_axis_tready, "beat taken while busy")
	`RC4_ASSERT_NEXT(a_res_hold, res_valid && !res_ready, res_valid && $stable(res), "pending result lost")

endmodule

`default_nettype wire

// File: dv/rc4_checker.sv
// rc4 stream cipher checker: tracks key writes and beats, predicts each result and compares
`default_nettype none

module rc4_checker #(
	parameter int MAX_KEY_BYTES = 16
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            s_axis_tvalid,
	input  wire logic                            s_axis_tready,
	input  wire logic [7:0]                      s_axis_tdata,  // data_in
	input  wire logic                            s_axis_tuser,  // command
	input  wire logic                            s_axis_tlast,
	input  wire logic                            m_axis_tvalid,
	input  wire logic                            m_axis_tready,
	input  wire logic [7:0]                      m_axis_tdata,  // data_out
	input  wire logic [1:0]                      m_axis_tuser,  // not_keyed, rekey_done
	input  wire logic                            m_axis_tlast,
	input  wire logic                            wr_en,
	input  wire logic [rc4_pkg::REG_IDX_W-1:0]   wr_index,
	input  wire logic [rc4_pkg::REG_DATA_W-1:0]  wr_data,
	output int                                   mismatches,
	output int                                   pending
);
	import rc4_pkg::*;

	logic [7:0]           perm [256];
	logic [7:0]           idx_i;
	logic [7:0]           idx_j;
	logic                 keyed;
	logic [63:0]          key_lo;
	logic [63:0]          key_hi;
	logic [KEY_LEN_W-1:0] key_len;
	rc4_res_t             cipher_q [$];
	int                   errs = 0;

	function automatic rc4_res_t cipher_beat(rc4_item_t it);
		rc4_res_t   r;
		int         len;
		int         n;
		int         k;
		logic [7:0] j;
		logic [7:0] a;
		logic [7:0] b;
		logic [7:0] kb;
		r = '0;
		r.last = it.last;
		if (it.cmd == CMD_REKEY) begin
			len = key_len;
			if (len == 0) len = 1;
			if (len > MAX_KEY_BYTES) len = MAX_KEY_BYTES;
			if (len > 16) len = 16;
			for (n = 0; n < 256; n++) perm[n] = 8'(n);
			j = 8'd0;
			for (n = 0; n < 256; n++) begin
				k = n % len;
				kb = (k < 8) ? key_lo[8*k +: 8] : key_hi[8*(k-8) +: 8];
				j = j + perm[n] + kb;
				a = perm[n];
				perm[n] = perm[j];
				perm[j] = a;
			end
			idx_i = 8'd0;
			idx_j = 8'd0;
			keyed = 1'b1;
			r.rekey_done = 1'b1;
		end else if (!keyed) begin
			r.data = it.data;
			r.not_keyed = 1'b1;
		end else begin
			idx_i = idx_i + 8'd1;
			a = perm[idx_i];
			idx_j = idx_j + a;
			b = perm[idx_j];
			perm[idx_i] = b;
			perm[idx_j] = a;
			r.data = it.data ^ perm[8'(a + b)];
		end
		return r;
	endfunction

	task automatic report_field(string name, logic [7:0] want, logic [7:0] got);
		$display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
		errs++;
	endtask

	always @(posedge clk or negedge arst_n) begin : monitor
		rc4_res_t got;
		rc4_res_t want;
		if (!arst_n) begin
			key_lo = '0;
			key_hi = '0;
			key_len = KEY_LEN_RESET;
			idx_i = 8'd0;
			idx_j = 8'd0;
			keyed = 1'b0;
			cipher_q.delete();
			pending <= 0;
			mismatches <= errs;
		end else begin
			if (wr_en) begin
				case (wr_index)
					REG_KEY_LO:  key_lo = wr_data;
					REG_KEY_HI:  key_hi = wr_data;
					REG_KEY_LEN: key_len = wr_data[KEY_LEN_W-1:0];
					default: ;
				endcase
			end
			if (s_axis_tvalid && s_axis_tready)
				cipher_q.push_back(cipher_beat({s_axis_tuser, s_axis_tdata, s_axis_tlast}));
			if (m_axis_tvalid && m_axis_tready) begin
				got = {m_axis_tdata, m_axis_tuser[0], m_axis_tuser[1], m_axis_tlast};
				if (cipher_q.size() == 0) begin
					$display("%0t: output beat with nothing expected, expected none, actual %h",
						$time, got);
					errs++;
				end else begin
					want = cipher_q.pop_front();
					if (got.data !== want.data) report_field("data_out", want.data, got.data);
					if (got.rekey_done !== want.rekey_done)
						report_field("rekey_done", want.rekey_done, got.rekey_done);
					if (got.not_keyed !== want.not_keyed)
						report_field("not_keyed", want.not_keyed, got.not_keyed);
					if (got.last !== want.last) report_field("last_out", want.last, got.last);
				end
			end
			mismatches <= errs;
			pending <= cipher_q.size();
		end
	end

endmodule

`default_nettype wire

// File: dv/tb_top.sv
// rc4 stream cipher testbench top: clock, reset, key writes, beat stimulus and verdict
`default_nettype none

module tb_top;
	import rc4_pkg::*;

	localparam int KEY_MAX      = 16;
	localparam int CYCLE_LIMIT  = 400000;
	localparam int RANDOM_ITEMS = 600;
	localparam int PHASES       = 8;
	localparam logic [REG_IDX_W-1:0] REG_UNUSED = 2'd3;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_axis_tvalid = 1'b0;
	logic                  s_axis_tready;
	logic [7:0]            s_axis_tdata = 8'd0;
	logic                  s_axis_tuser = CMD_DATA;
	logic                  s_axis_tlast = 1'b0;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	logic [7:0]            m_axis_tdata;
	logic [1:0]            m_axis_tuser;
	logic                  m_axis_tlast;
	logic                  wr_en = 1'b0;
	logic [REG_IDX_W-1:0]  wr_index = REG_KEY_LO;
	logic [REG_DATA_W-1:0] wr_data = '0;
	logic                  calm = 1'b0;
	int                    mismatches;
	int                    pending;
	int                    cycle_count = 0;

	rc4_stream_cipher #(.MAX_KEY_BYTES(KEY_MAX)) dut (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser), .s_axis_tlast(s_axis_tlast),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser), .m_axis_tlast(m_axis_tlast),
		.wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data)
	);

	rc4_checker #(.MAX_KEY_BYTES(KEY_MAX)) u_checker (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser), .s_axis_tlast(s_axis_tlast),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser), .m_axis_tlast(m_axis_tlast),
		.wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data),
		.mismatches(mismatches), .pending(pending)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("CHECK FAILED");
		$finish;
	end

	initial begin
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (!calm && $urandom_range(0, 4) == 0) begin
				m_axis_tready <= 1'b0;
				repeat ($urandom_range(1, 6) - 1) @(posedge clk);
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	task automatic send_beat(logic cmd, logic [7:0] data, logic last);
		if (!calm && $urandom_range(0, 3) == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= cmd;
		s_axis_tdata <= data;
		s_axis_tlast <= last;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
	endtask

	task automatic settle;
		s_axis_tvalid <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_reg(logic [REG_IDX_W-1:0] idx, logic [REG_DATA_W-1:0] val);
		@(posedge clk);
		wr_en <= 1'b1;
		wr_index <= idx;
		wr_data <= val;
		@(posedge clk);
		wr_en <= 1'b0;
	endtask

	initial begin
		logic [REG_DATA_W-1:0] len_word;
		int                    ph;
		int                    k;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// data before any key schedule passes through
		send_beat(CMD_DATA, 8'h00, 1'b0);
		send_beat(CMD_DATA, 8'hFF, 1'b1);
		send_beat(CMD_DATA, 8'hA5, 1'b0);
		// reset key: all zero bytes, length 16
		send_beat(CMD_REKEY, 8'hFF, 1'b1);
		send_beat(CMD_DATA, 8'h00, 1'b1);
		send_beat(CMD_DATA, 8'hFF, 1'b0);
		send_beat(CMD_DATA, 8'h5A, 1'b1);
		send_beat(CMD_DATA, 8'h00, 1'b0);

		settle;
		write_reg(REG_KEY_LO, '1);
		write_reg(REG_KEY_HI, '1);
		write_reg(REG_KEY_LEN, 64'd1);
		send_beat(CMD_REKEY, 8'h00, 1'b0);
		send_beat(CMD_DATA, 8'hFF, 1'b1);
		send_beat(CMD_DATA, 8'h00, 1'b0);

		settle;
		write_reg(REG_KEY_LO, 64'h0000_0000_0079_654B);
		write_reg(REG_KEY_HI, '0);
		write_reg(REG_KEY_LEN, 64'd3);
		send_beat(CMD_REKEY, 8'h3C, 1'b1);
		send_beat(CMD_DATA, 8'h00, 1'b0);
		send_beat(CMD_DATA, 8'h00, 1'b0);
		send_beat(CMD_DATA, 8'h00, 1'b1);

		// zero length acts as one byte
		settle;
		write_reg(REG_KEY_LEN, 64'd0);
		send_beat(CMD_REKEY, 8'h00, 1'b0);
		send_beat(CMD_DATA, 8'hC3, 1'b1);
		send_beat(CMD_DATA, 8'h81, 1'b0);

		// length above the cap saturates
		settle;
		write_reg(REG_KEY_LO, {$urandom, $urandom});
		write_reg(REG_KEY_HI, {$urandom, $urandom});
		write_reg(REG_KEY_LEN, '1);
		send_beat(CMD_REKEY, 8'hFF, 1'b1);
		send_beat(CMD_DATA, 8'h7E, 1'b0);
		send_beat(CMD_DATA, 8'hFF, 1'b1);

		// write to an unused index is dropped
		settle;
		write_reg(REG_UNUSED, {$urandom, $urandom});
		send_beat(CMD_REKEY, 8'h00, 1'b0);
		send_beat(CMD_DATA, 8'h12, 1'b1);

		for (ph = 0; ph < PHASES; ph++) begin
			settle;
			calm <= (ph == PHASES - 1);
			len_word = {$urandom, $urandom};
			case (ph)
				0:       len_word[KEY_LEN_W-1:0] = 5'd16;
				1:       len_word[KEY_LEN_W-1:0] = 5'd1;
				2:       len_word[KEY_LEN_W-1:0] = 5'd0;
				3:       len_word[KEY_LEN_W-1:0] = 5'd31;
				default: len_word[KEY_LEN_W-1:0] = 5'($urandom_range(1, 16));
			endcase
			write_reg(REG_KEY_LO, {$urandom, $urandom});
			write_reg(REG_KEY_HI, {$urandom, $urandom});
			write_reg(REG_KEY_LEN, len_word);
			if ($urandom_range(0, 2) == 0) write_reg(REG_UNUSED, {$urandom, $urandom});
			if (ph == 0 || $urandom_range(0, 3) != 0)
				send_beat(CMD_REKEY, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
			for (k = 0; k < RANDOM_ITEMS / PHASES; k++)
				send_beat(($urandom_range(0, 49) == 0) ? CMD_REKEY : CMD_DATA,
					8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
		end

		settle;
		if (mismatches == 0 && pending == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

`default_nettype wire
